// ===== rtl/bmw_pkg.sv =====
// ----------------------------------------------------------------------------
// bmw_pkg
// Shared sizes, register indexes and types of the binary morphology window.
// ----------------------------------------------------------------------------
package bmw_pkg;

    // Line store depth and largest element half size
    localparam int MAX_WIDTH  = 2048;
    localparam int MAX_RADIUS = 3;

    // Window geometry: side, bits, and stored lines above the current pixel
    localparam int KERNEL    = 2 * MAX_RADIUS + 1;
    localparam int WIN_BITS  = KERNEL * KERNEL;
    localparam int LINES     = KERNEL - 1;
    localparam int WIN_IDX_W = $clog2(WIN_BITS);
    localparam int RAD_W     = $clog2(MAX_RADIUS + 1);

    // Mask register layout: 7x7 with centre at offset 3
    localparam int MASK_SIDE = 7;
    localparam int MASK_CTR  = 3;
    localparam int MASK_W    = MASK_SIDE * MASK_SIDE;

    // Field widths
    localparam int COL_W  = 11;
    localparam int ROW_W  = 16;
    localparam int IMGW_W = 12;
    localparam int HALF_W = 2;
    localparam int ADDR_W = $clog2(MAX_WIDTH);

    // Configuration port
    localparam int CFG_W     = MASK_W;
    localparam int CFG_IDX_W = 3;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_MODE         = 3'd0,
        CFG_WINDOW_MASK  = 3'd1,
        CFG_HALF_WIDTH   = 3'd2,
        CFG_HALF_HEIGHT  = 3'd3,
        CFG_IMAGE_WIDTH  = 3'd4,
        CFG_IMAGE_HEIGHT = 3'd5
    } t_cfg_idx;

    // Operating modes
    localparam logic MODE_ERODE  = 1'b0;
    localparam logic MODE_DILATE = 1'b1;

    // Register reset values
    localparam logic [MASK_W-1:0] RST_MASK   = MASK_W'(1) << (MASK_CTR * MASK_SIDE + MASK_CTR);
    localparam logic [HALF_W-1:0] RST_HALF   = HALF_W'(1);
    localparam logic [IMGW_W-1:0] RST_IMG_W  = IMGW_W'(640);
    localparam logic [ROW_W-1:0]  RST_IMG_H  = ROW_W'(480);

    // Structuring element settings handed to the reduction
    typedef struct packed {
        logic              mode;
        logic [MASK_W-1:0] mask;
        logic [RAD_W-1:0]  hw;
        logic [RAD_W-1:0]  hh;
    } t_elem;

endpackage

// ===== rtl/bmw_ram.sv =====
// ----------------------------------------------------------------------------
// bmw_ram
// Simple dual-port RAM: one write port, one read port with registered data.
// ----------------------------------------------------------------------------
module bmw_ram #(
    parameter int WIDTH = 6,
    parameter int DEPTH = 2048
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // Write port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // Read port, old data on a same-address write
    always_ff @(posedge i_clk) begin
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// ===== rtl/bmw_reduce.sv =====
// ----------------------------------------------------------------------------
// bmw_reduce
// Combines the window centre with every masked pixel inside the configured
// half sizes: AND for erosion, OR for dilation.
// ----------------------------------------------------------------------------
module bmw_reduce
    import bmw_pkg::*;
(
    input  logic [WIN_BITS-1:0] i_win,
    input  t_elem               i_elem,
    output logic                o_result
);

    logic [WIN_BITS-1:0] w_and_term;
    logic [WIN_BITS-1:0] w_or_term;
    logic                w_centre;

    // Centre sits hh rows and hw columns back from the newest pixel
    assign w_centre = i_win[WIN_IDX_W'(int'(i_elem.hw) * KERNEL + int'(i_elem.hh))];

    // One term per element offset
    for (genvar gy = 0; gy < KERNEL; gy++) begin : g_row
        for (genvar gx = 0; gx < KERNEL; gx++) begin : g_col
            localparam int DY   = gy - MAX_RADIUS;
            localparam int DX   = gx - MAX_RADIUS;
            localparam int ADY  = (DY < 0) ? -DY : DY;
            localparam int ADX  = (DX < 0) ? -DX : DX;
            localparam int MBIT = (DY + MASK_CTR) * MASK_SIDE + (DX + MASK_CTR);
            localparam int E    = gy * KERNEL + gx;

            logic                 w_sel;
            logic [WIN_IDX_W-1:0] w_idx;
            logic                 w_tap;

            // Offset inside the half sizes and selected by the mask
            assign w_sel = (i_elem.hh >= RAD_W'(ADY)) && (i_elem.hw >= RAD_W'(ADX))
                           && i_elem.mask[MBIT];
            assign w_idx = WIN_IDX_W'((int'(i_elem.hw) - DX) * KERNEL
                                      + int'(i_elem.hh) - DY);
            assign w_tap = w_sel ? i_win[w_idx] : 1'b0;

            assign w_and_term[E] = ~w_sel | w_tap;
            assign w_or_term[E]  = w_tap;
        end
    end

    // Pick the combination
    always_comb begin
        case (i_elem.mode)
            MODE_ERODE:  o_result = w_centre & (&w_and_term);
            MODE_DILATE: o_result = w_centre | (|w_or_term);
            default:     o_result = w_centre;
        endcase
    end

endmodule

// ===== rtl/binary_morphology_window.sv =====
// ----------------------------------------------------------------------------
// binary_morphology_window
// Binary erosion / dilation over a 7x7 window on a raster pixel stream.
// A six-line store feeds a 49-bit window; each interior position yields one
// result tagged with its row and column, border positions yield nothing.
// ----------------------------------------------------------------------------
//
//  channel  | handshake          | payload
//  ---------+--------------------+-------------------------------------------
//  pixel in | i_valid / o_ready  | i_pixel
//  result   | o_valid / i_ready  | o_result_pixel, o_out_row, o_out_col
//  config   | i_cfg_we           | i_cfg_index, i_cfg_data
//
// One pixel per cycle sustained while no result is stalled; a result is
// loaded into the output register at the edge that takes its pixel, and
// the line store read for the next column is issued at that edge, so the
// store's single read port keeps up with the stream. Reset clears the
// window, position counters and output valid bit; the line store keeps its
// contents. A stalled result holds the output register and stops intake only while it waits.
// ----------------------------------------------------------------------------
module binary_morphology_window
    import bmw_pkg::*;
(
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    // pixel requests
    input  logic                 i_valid,
    output logic                 o_ready,
    input  logic                 i_pixel,
    // results
    output logic                 o_valid,
    input  logic                 i_ready,
    output logic                 o_result_pixel,
    output logic [ROW_W-1:0]     o_out_row,
    output logic [COL_W-1:0]     o_out_col,
    // configuration writes
    input  logic                 i_cfg_we,
    input  logic [CFG_IDX_W-1:0] i_cfg_index,
    input  logic [CFG_W-1:0]     i_cfg_data
);

    // Configuration registers
    logic              r_mode;
    logic [MASK_W-1:0] r_mask;
    logic [HALF_W-1:0] r_half_w;
    logic [HALF_W-1:0] r_half_h;
    logic [IMGW_W-1:0] r_img_w;
    logic [ROW_W-1:0]  r_img_h;

    // Position, window and line store forwarding
    logic [COL_W-1:0]    r_col,    n_col;
    logic [ROW_W-1:0]    r_row,    n_row;
    logic [WIN_BITS-1:0] r_win,    n_win;
    logic                r_fwd;
    logic [LINES-1:0]    r_fwd_data;

    // Output register
    logic             r_out_valid;
    logic             r_res_pix;
    logic [ROW_W-1:0] r_res_row;
    logic [COL_W-1:0] r_res_col;

    logic              w_accept;
    logic              w_emit;
    logic              w_result;
    logic [LINES-1:0]  w_ram_rdata;
    logic [LINES-1:0]  w_above;
    logic [KERNEL-1:0] w_colvec;
    logic [IMGW_W-1:0] w_width;
    logic [ROW_W-1:0]  w_height;
    logic [RAD_W-1:0]  w_hw;
    logic [RAD_W-1:0]  w_hh;
    logic              w_col_wrap;
    logic              w_row_wrap;
    t_elem             w_elem;

    // Configuration writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode   <= MODE_ERODE;
            r_mask   <= RST_MASK;
            r_half_w <= RST_HALF;
            r_half_h <= RST_HALF;
            r_img_w  <= RST_IMG_W;
            r_img_h  <= RST_IMG_H;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                CFG_MODE:         r_mode   <= i_cfg_data[0];
                CFG_WINDOW_MASK:  r_mask   <= i_cfg_data[MASK_W-1:0];
                CFG_HALF_WIDTH:   r_half_w <= i_cfg_data[HALF_W-1:0];
                CFG_HALF_HEIGHT:  r_half_h <= i_cfg_data[HALF_W-1:0];
                CFG_IMAGE_WIDTH:  r_img_w  <= i_cfg_data[IMGW_W-1:0];
                CFG_IMAGE_HEIGHT: r_img_h  <= i_cfg_data[ROW_W-1:0];
                default:          ;
            endcase
        end
    end

    // Clamp sizes into their usable ranges
    always_comb begin
        if (r_img_w == '0) begin
            w_width = IMGW_W'(1);
        end else if (r_img_w > IMGW_W'(MAX_WIDTH)) begin
            w_width = IMGW_W'(MAX_WIDTH);
        end else begin
            w_width = r_img_w;
        end
        w_height = (r_img_h == '0) ? ROW_W'(1) : r_img_h;
        w_hw = (r_half_w > HALF_W'(MAX_RADIUS)) ? RAD_W'(MAX_RADIUS) : RAD_W'(r_half_w);
        w_hh = (r_half_h > HALF_W'(MAX_RADIUS)) ? RAD_W'(MAX_RADIUS) : RAD_W'(r_half_h);
    end

    // Take a pixel when the output register is free or being emptied
    assign o_ready  = !r_out_valid || i_ready;
    assign w_accept = i_valid && o_ready;

    // Line store: read the next column at each request, write the current
    bmw_ram #(
        .WIDTH (LINES),
        .DEPTH (MAX_WIDTH)
    ) u_line_store (
        .i_clk   (i_clk),
        .i_we    (w_accept),
        .i_waddr (ADDR_W'(r_col)),
        .i_wdata (w_colvec[LINES-1:0]),
        .i_raddr (ADDR_W'(n_col)),
        .o_rdata (w_ram_rdata)
    );

    // Forward the column just written when it is read again at once
    assign w_above  = r_fwd ? r_fwd_data : w_ram_rdata;
    assign w_colvec = {w_above, i_pixel};
    assign n_win    = {r_win[WIN_BITS-KERNEL-1:0], w_colvec};

    // Advance the raster position
    assign w_col_wrap = ({1'b0, r_col} + 12'd1) >= w_width;
    assign w_row_wrap = ({1'b0, r_row} + 17'd1) >= {1'b0, w_height};

    always_comb begin
        n_col = r_col;
        n_row = r_row;
        if (w_accept) begin
            if (w_col_wrap) begin
                n_col = '0;
                n_row = w_row_wrap ? '0 : r_row + ROW_W'(1);
            end else begin
                n_col = r_col + COL_W'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_col      <= '0;
            r_row      <= '0;
            r_win      <= '0;
            r_fwd      <= 1'b0;
        end else begin
            r_col <= n_col;
            r_row <= n_row;
            r_fwd <= w_accept && (n_col == r_col);
            if (w_accept) begin
                r_win <= n_win;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_fwd_data <= w_colvec[LINES-1:0];
    end

    // Combine the window under the structuring element
    assign w_elem = '{mode: r_mode, mask: r_mask, hw: w_hw, hh: w_hh};

    bmw_reduce u_reduce (
        .i_win    (n_win),
        .i_elem   (w_elem),
        .o_result (w_result)
    );

    // Interior positions only
    assign w_emit = (r_row >= ROW_W'({w_hh, 1'b0})) && (r_col >= COL_W'({w_hw, 1'b0}));

    // Output register: load a new result, drop it once taken
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_accept && w_emit) begin
            r_out_valid <= 1'b1;
        end else if (i_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept && w_emit) begin
            r_res_pix <= w_result;
            r_res_row <= r_row - ROW_W'(w_hh);
            r_res_col <= r_col - COL_W'(w_hw);
        end
    end

    assign o_valid        = r_out_valid;
    assign o_result_pixel = r_res_pix;
    assign o_out_row      = r_res_row;
    assign o_out_col      = r_res_col;

endmodule

// ===== rtl/bmw_chk.sv =====
// ----------------------------------------------------------------------------
// bmw_chk
// Port-level checks for the binary morphology window, bound to the top level.
// ----------------------------------------------------------------------------
module bmw_chk
    import bmw_pkg::*;
(
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_valid,
    input  logic                 o_ready,
    input  logic                 o_valid,
    input  logic                 i_ready,
    input  logic                 o_result_pixel,
    input  logic [ROW_W-1:0]     o_out_row,
    input  logic [COL_W-1:0]     o_out_col
);

    // A stalled result holds its payload
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !i_ready |=> o_valid && $stable(o_result_pixel)
                                && $stable(o_out_row) && $stable(o_out_col))
        else $error("stalled result changed");

    // A new result only follows a taken pixel
    a_out_cause: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !$past(o_valid && !i_ready) |-> $past(i_valid && o_ready))
        else $error("result without a pixel request");

    // No intake while a result waits
    a_no_overrun: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !i_ready |-> !o_ready)
        else $error("pixel taken while result stalled");

    // Reset empties the output
    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_valid)
        else $error("result present after reset");

endmodule

bind binary_morphology_window bmw_chk u_bmw_chk (.*);

// ===== sim/tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the binary morphology window. A scoreboard class
// predicts every result from the accepted pixel stream and the register
// settings, and checks each result against the oldest prediction. Directed
// frames cover the extremes first and one long result hold-off. Random
// frames follow, with random element settings, bursty pixel requests, a
// patterned result stall and register writes in mid-frame.
// ----------------------------------------------------------------------------
module tb;
    import bmw_pkg::*;

    localparam int ITEM_TARGET    = 1500;
    localparam int LONG_HOLD      = 400;
    localparam int PATTERN_SPAN   = 128;
    localparam int SETTLE_CYCLES  = 4;
    localparam int WATCHDOG_LIMIT = 5000;
    localparam int MAX_PRINTS     = 50;

    typedef struct packed {
        logic             value;
        logic [ROW_W-1:0] row;
        logic [COL_W-1:0] col;
    } t_morph_result;

    typedef struct {
        logic              mode;
        logic [MASK_W-1:0] mask;
        logic [HALF_W-1:0] hw;
        logic [HALF_W-1:0] hh;
        logic [IMGW_W-1:0] width;
        logic [ROW_W-1:0]  height;
    } t_morph_setting;

    // Predicts results of the window and checks the ones the block produces
    class morph_scoreboard;
        logic                mode;
        logic [MASK_W-1:0]   mask;
        logic [HALF_W-1:0]   half_w;
        logic [HALF_W-1:0]   half_h;
        logic [IMGW_W-1:0]   img_w;
        logic [ROW_W-1:0]    img_h;
        logic [LINES-1:0]    column_hist [MAX_WIDTH];
        logic [WIN_BITS-1:0] window;
        int unsigned         col_pos;
        int unsigned         row_pos;
        t_morph_result       expected_q [$];
        int                  errors;

        function new();
            mode    = MODE_ERODE;
            mask    = RST_MASK;
            half_w  = RST_HALF;
            half_h  = RST_HALF;
            img_w   = RST_IMG_W;
            img_h   = RST_IMG_H;
            foreach (column_hist[i]) column_hist[i] = '0;
            window  = '0;
            col_pos = 0;
            row_pos = 0;
            errors  = 0;
        endfunction

        function void set_register(t_cfg_idx idx, logic [CFG_W-1:0] data);
            case (idx)
                CFG_MODE:         mode   = data[0];
                CFG_WINDOW_MASK:  mask   = data[MASK_W-1:0];
                CFG_HALF_WIDTH:   half_w = data[HALF_W-1:0];
                CFG_HALF_HEIGHT:  half_h = data[HALF_W-1:0];
                CFG_IMAGE_WIDTH:  img_w  = data[IMGW_W-1:0];
                CFG_IMAGE_HEIGHT: img_h  = data[ROW_W-1:0];
                default: ;
            endcase
        endfunction

        function int unsigned eff_width();
            int unsigned w;
            w = img_w;
            if (w < 1) w = 1;
            if (w > MAX_WIDTH) w = MAX_WIDTH;
            return w;
        endfunction

        function int unsigned eff_height();
            return (img_h == 0) ? 1 : img_h;
        endfunction

        function int clamp_radius(logic [HALF_W-1:0] h);
            return (h > MAX_RADIUS) ? MAX_RADIUS : int'(h);
        endfunction

        // Pixels still to come before the raster position returns to the origin
        function int unsigned frame_remaining();
            int unsigned w;
            int unsigned h;
            int unsigned row_left;
            w = eff_width();
            h = eff_height();
            row_left = (col_pos >= w) ? 1 : w - col_pos;
            if (row_pos + 1 >= h) return row_left;
            return row_left + (h - row_pos - 1) * w;
        endfunction

        function int pending_count();
            return expected_q.size();
        endfunction

        task report_mismatch(string what);
            errors++;
            if (errors <= MAX_PRINTS) $display("MISMATCH: %s", what);
        endtask

        // Shift the pixel into the window and predict the centre result
        function void note_pixel(logic px);
            int unsigned   w;
            int unsigned   h;
            int unsigned   c;
            int            hw;
            int            hh;
            int            dy;
            int            dx;
            int            pick;
            logic [KERNEL-1:0] colv;
            logic          acc;
            t_morph_result res;
            w  = eff_width();
            h  = eff_height();
            hw = clamp_radius(half_w);
            hh = clamp_radius(half_h);
            c  = (col_pos >= MAX_WIDTH) ? 0 : col_pos;
            colv = {column_hist[c], px};
            window = {window[WIN_BITS-KERNEL-1:0], colv};
            column_hist[c] = colv[LINES-1:0];
            if (row_pos >= 2 * hh && c >= 2 * hw) begin
                acc = window[hw * KERNEL + hh];
                for (dy = -hh; dy <= hh; dy++) begin
                    for (dx = -hw; dx <= hw; dx++) begin
                        if (mask[(dy + MASK_CTR) * MASK_SIDE + dx + MASK_CTR]) begin
                            pick = (hw - dx) * KERNEL + (hh - dy);
                            if (mode == MODE_DILATE) acc = acc | window[pick];
                            else acc = acc & window[pick];
                        end
                    end
                end
                res.value = acc;
                res.row   = ROW_W'(row_pos - hh);
                res.col   = COL_W'(c - hw);
                expected_q.push_back(res);
            end
            // Advance the raster position
            if (c + 1 >= w) begin
                col_pos = 0;
                row_pos = (row_pos + 1 >= h) ? 0 : ((row_pos + 1) & 16'hFFFF);
            end else begin
                col_pos = c + 1;
            end
        endfunction

        task check_result(t_morph_result got);
            t_morph_result want;
            if (expected_q.size() == 0) begin
                report_mismatch($sformatf("unexpected result value %0b row %0d col %0d",
                                          got.value, got.row, got.col));
            end else begin
                want = expected_q.pop_front();
                if (got.value !== want.value)
                    report_mismatch($sformatf("value %0b, expected %0b at row %0d col %0d",
                                              got.value, want.value, want.row, want.col));
                if (got.row !== want.row)
                    report_mismatch($sformatf("row %0d, expected %0d", got.row, want.row));
                if (got.col !== want.col)
                    report_mismatch($sformatf("col %0d, expected %0d", got.col, want.col));
            end
        endtask

        task close_out();
            if (expected_q.size() != 0)
                report_mismatch($sformatf("%0d expected results never arrived",
                                          expected_q.size()));
        endtask
    endclass

    logic                 i_clk       = 1'b0;
    logic                 i_rst_n     = 1'b0;
    logic                 i_valid     = 1'b0;
    logic                 o_ready;
    logic                 i_pixel     = 1'b0;
    logic                 o_valid;
    logic                 i_ready     = 1'b0;
    logic                 o_result_pixel;
    logic [ROW_W-1:0]     o_out_row;
    logic [COL_W-1:0]     o_out_col;
    logic                 i_cfg_we    = 1'b0;
    logic [CFG_IDX_W-1:0] i_cfg_index = CFG_MODE;
    logic [CFG_W-1:0]     i_cfg_data  = '0;

    morph_scoreboard sb;
    int              pixels_sent = 0;
    int              gap_max     = 0;
    int              burst_left  = 0;
    int              idle_cycles = 0;

    logic [15:0]     ready_pattern = 16'hFFFF;
    int              ready_tick    = 0;
    int              hold_left     = 0;
    logic            hold_toggle   = 1'b0;
    logic            hold_seen     = 1'b0;

    binary_morphology_window i_dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_valid        (i_valid),
        .o_ready        (o_ready),
        .i_pixel        (i_pixel),
        .o_valid        (o_valid),
        .i_ready        (i_ready),
        .o_result_pixel (o_result_pixel),
        .o_out_row      (o_out_row),
        .o_out_col      (o_out_col),
        .i_cfg_we       (i_cfg_we),
        .i_cfg_index    (i_cfg_index),
        .i_cfg_data     (i_cfg_data)
    );

    always begin
        #10 i_clk = 1'b1;
        #10 i_clk = 1'b0;
    end

    // Note accepted pixel requests, then check accepted results
    always @(posedge i_clk) begin : monitor
        t_morph_result got;
        if (i_rst_n) begin
            if (i_valid && o_ready) sb.note_pixel(i_pixel);
            if (o_valid && i_ready) begin
                got = '{value: o_result_pixel, row: o_out_row, col: o_out_col};
                sb.check_result(got);
            end
        end
    end

    // End the run when nothing moves for too long
    always @(posedge i_clk) begin
        if ((i_valid && o_ready) || (o_valid && i_ready)) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("Verification failed");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    function automatic logic [15:0] next_ready_pattern();
        logic [15:0] p;
        case ($urandom_range(0, 3))
            0:       p = 16'hFFFF;
            1:       p = 16'($urandom);
            2:       p = 16'($urandom & $urandom);
            default: p = 16'($urandom | $urandom);
        endcase
        return p | 16'h0001;
    endfunction

    // Stall results on a rotating pattern; hold off entirely when asked
    always @(posedge i_clk) begin
        if (hold_toggle != hold_seen) begin
            hold_seen <= hold_toggle;
            hold_left <= LONG_HOLD;
            i_ready   <= 1'b0;
        end else if (hold_left > 0) begin
            hold_left <= hold_left - 1;
            i_ready   <= 1'b0;
        end else begin
            i_ready   <= ready_pattern[0];
        end
        if (ready_tick == PATTERN_SPAN - 1) begin
            ready_tick    <= 0;
            ready_pattern <= next_ready_pattern();
        end else begin
            ready_tick    <= ready_tick + 1;
            ready_pattern <= {ready_pattern[0], ready_pattern[15:1]};
        end
    end

    function automatic logic [MASK_W-1:0] square_mask(int radius);
        logic [MASK_W-1:0] m;
        m = '0;
        for (int dy = -radius; dy <= radius; dy++)
            for (int dx = -radius; dx <= radius; dx++)
                m[(dy + MASK_CTR) * MASK_SIDE + dx + MASK_CTR] = 1'b1;
        return m;
    endfunction

    function automatic t_morph_setting random_setting();
        t_morph_setting s;
        s.mode = 1'($urandom_range(0, 1));
        case ($urandom_range(0, 5))
            0:       s.mask = '1;
            1:       s.mask = '0;
            2:       s.mask = square_mask($urandom_range(1, 3));
            5:       s.mask = MASK_W'({$urandom, $urandom} & {$urandom, $urandom});
            default: s.mask = MASK_W'({$urandom, $urandom});
        endcase
        s.hw = HALF_W'($urandom_range(0, 3));
        s.hh = HALF_W'($urandom_range(0, 3));
        case ($urandom_range(0, 9))
            0:       s.width = '0;
            1:       s.width = IMGW_W'($urandom_range(24, 64));
            default: s.width = IMGW_W'($urandom_range(1, 16));
        endcase
        s.height = ($urandom_range(0, 11) == 0) ? '0 : ROW_W'($urandom_range(1, 10));
        return s;
    endfunction

    task automatic write_register(t_cfg_idx idx, logic [CFG_W-1:0] data);
        i_cfg_we    <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        sb.set_register(idx, data);
        @(posedge i_clk);
    endtask

    // Write the element registers and the height; the width only at a frame boundary
    task automatic write_setting(t_morph_setting s, bit whole_frame);
        write_register(CFG_MODE, CFG_W'(s.mode));
        write_register(CFG_WINDOW_MASK, CFG_W'(s.mask));
        write_register(CFG_HALF_WIDTH, CFG_W'(s.hw));
        write_register(CFG_HALF_HEIGHT, CFG_W'(s.hh));
        write_register(CFG_IMAGE_HEIGHT, CFG_W'(s.height));
        if (whole_frame) write_register(CFG_IMAGE_WIDTH, CFG_W'(s.width));
        i_cfg_we <= 1'b0;
    endtask

    // Offer one pixel request and hold it until taken
    task automatic send_pixel(logic px);
        i_valid <= 1'b1;
        i_pixel <= px;
        do @(posedge i_clk); while (!o_ready);
        pixels_sent++;
    endtask

    // Send pixels in bursts with random gaps; density is the percentage of ones
    task automatic stream_pixels(int count, int density);
        int n;
        for (n = 0; n < count; n++) begin
            send_pixel($urandom_range(0, 99) < density);
            if (burst_left > 0) begin
                burst_left--;
            end else begin
                burst_left = $urandom_range(1, 32);
                if (gap_max > 0) begin
                    i_valid <= 1'b0;
                    repeat ($urandom_range(1, gap_max)) @(posedge i_clk);
                end
            end
        end
    endtask

    // Stop sending and wait until every predicted result has come out
    task automatic wait_drained();
        i_valid <= 1'b0;
        @(posedge i_clk);
        while (sb.pending_count() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic random_phase();
        t_morph_setting s;
        int             total;
        int             density;
        case ($urandom_range(0, 2))
            0:       gap_max = 0;
            1:       gap_max = 2;
            default: gap_max = 6;
        endcase
        s = random_setting();
        density = (s.mode == MODE_ERODE) ? $urandom_range(55, 100) : $urandom_range(0, 45);
        if ($urandom_range(0, 4) == 0) density = $urandom_range(0, 100);
        write_setting(s, 1'b1);
        total = sb.frame_remaining() * $urandom_range(1, 2);
        if (total > 2 && $urandom_range(0, 3) == 0) begin
            // Change the element part way through the frame
            stream_pixels($urandom_range(1, total - 1), density);
            wait_drained();
            write_setting(random_setting(), 1'b0);
            stream_pixels(sb.frame_remaining(), density);
        end else begin
            stream_pixels(total, density);
        end
        wait_drained();
    endtask

    initial begin : main
        t_morph_setting s;
        int             start_count;
        sb = new();
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Zero geometry and half sizes: every pixel is its own result
        s = '{mode: MODE_ERODE, mask: '1, hw: '0, hh: '0, width: '0, height: '0};
        write_setting(s, 1'b1);
        send_pixel(1'b1);
        send_pixel(1'b0);
        wait_drained();
        s.mode = MODE_DILATE;
        write_setting(s, 1'b1);
        send_pixel(1'b0);
        send_pixel(1'b1);
        wait_drained();

        // Smallest 3x3 frames: erode a solid block, dilate a lone corner pixel
        s = '{mode: MODE_ERODE, mask: square_mask(1), hw: 2'd1, hh: 2'd1,
              width: 12'd3, height: 16'd3};
        write_setting(s, 1'b1);
        stream_pixels(9, 100);
        wait_drained();
        s.mode = MODE_DILATE;
        write_setting(s, 1'b1);
        send_pixel(1'b1);
        stream_pixels(8, 0);
        wait_drained();

        // Frame too small for any interior position
        s.width  = 12'd2;
        s.height = 16'd2;
        write_setting(s, 1'b1);
        stream_pixels(4, 100);
        wait_drained();

        // Widest row: width register above the line store depth
        gap_max = 2;
        s = '{mode: MODE_DILATE, mask: MASK_W'({$urandom, $urandom}), hw: '0, hh: '0,
              width: '1, height: 16'd1};
        write_setting(s, 1'b1);
        stream_pixels(sb.frame_remaining(), 10);
        wait_drained();

        // Tallest frame setting, cut short by lowering the height mid-frame
        s = '{mode: MODE_ERODE, mask: '1, hw: 2'd3, hh: 2'd3, width: 12'd8, height: '1};
        write_setting(s, 1'b1);
        stream_pixels(72, 90);
        wait_drained();
        s = random_setting();
        s.height = 16'd2;
        write_setting(s, 1'b0);
        stream_pixels(sb.frame_remaining(), 60);
        wait_drained();

        // Hold results off for a long stretch while pixels keep coming
        gap_max = 0;
        s = random_setting();
        s.width  = 12'd10;
        s.height = 16'd12;
        write_setting(s, 1'b1);
        hold_toggle <= ~hold_toggle;
        stream_pixels(sb.frame_remaining(), 50);
        wait_drained();

        // Random frames
        start_count = pixels_sent;
        while (pixels_sent - start_count < ITEM_TARGET) random_phase();

        wait_drained();
        sb.close_out();
        if (sb.errors == 0) begin
            $display("Verification passed");
        end else begin
            $display("Verification failed");
        end
        $finish;
    end

endmodule
